>>> hw/rtl/smpq_pkg.sv
// shared types and constants for the slotted min priority queue
package smpq_pkg;

  localparam int SLOTS      = 64;
  localparam int KEY_W      = 32;
  localparam int ID_W       = 16;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int CAP_W      = 7;
  localparam int SLOT_NUM_W = 7;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_SERVE = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic             min_found;
    logic [IDX_W-1:0] min_idx;
    logic [KEY_W-1:0] min_key;
    logic [ID_W-1:0]  min_id;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } scan_t;

  // update broadcast to every cell
  typedef struct packed {
    logic             fill;
    logic             drain;
    logic             clear_all;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } wr_t;

endpackage

>>> hw/rtl/smpq_cell.sv
// one slot of the queue with its stage of the search chain
module smpq_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [smpq_pkg::IDX_W-1:0] slot_idx,
  input  smpq_pkg::wr_t          wr,
  input  smpq_pkg::scan_t        scan_in,
  output smpq_pkg::scan_t        scan_out
);
  import smpq_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [ID_W-1:0]  id;
  logic             hit;
  scan_t            scan_next;

  assign hit = (wr.idx == slot_idx);

  always_comb begin
    scan_next = scan_in;
    // ties go to the higher slot
    if (valid && (!scan_in.min_found || key <= scan_in.min_key)) begin
      scan_next.min_found = 1'b1;
      scan_next.min_idx   = slot_idx;
      scan_next.min_key   = key;
      scan_next.min_id    = id;
    end
    if (!valid && !scan_in.free_found) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = slot_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.clear_all) begin
      valid <= 1'b0;
    end else if (wr.fill && hit) begin
      valid <= 1'b1;
    end else if (wr.drain && hit) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.fill && hit) begin
      key <= wr.key;
      id  <= wr.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule

>>> hw/rtl/slotted_min_priority_queue_unit.sv
// top level of the slotted min priority queue
//
// input stream: s_tuser carries the command (enqueue, serve, peek, clear),
// s_tdata the identifier and key. output stream: m_tuser is the reject flag,
// m_tdata the slot number, identifier, key, occupancy and full/empty flags.
// capacity_limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce this.
// every slot is a cell in a chain of 64; a search token enters the first
// cell and moves one cell per clock. an accepted command scans in ST_SCAN,
// commits in ST_FINISH with its result registered; one is in flight at a time.
// the result sits in an output register; a new command is accepted while it
// waits, but the commit of that next command holds while m_tready is low.
// reset frees every slot, sets the count to zero and capacity to 64; no
// clearing pass is needed, slot contents are only read where valid.
// clear frees all slots at commit without touching keys or identifiers.
module slotted_min_priority_queue_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [smpq_pkg::CAP_W-1:0]          cfg_wr_data,  // capacity_limit
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [smpq_pkg::IN_DATA_W-1:0]      s_tdata,      // item_id, leave_key
  input  logic [smpq_pkg::CMD_W-1:0]          s_tuser,      // command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // slot_number, out_id, out_key, entry_total, is_full, is_empty
  output logic [smpq_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser       // status
);
  import smpq_pkg::*;

  localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t           state;
  logic [CAP_W-1:0] capacity_limit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt;
  cmd_t             cmd;
  logic [ID_W-1:0]  item_id;
  logic [KEY_W-1:0] leave_key;

  scan_t chain [SLOTS];
  scan_t last;
  wr_t   wr;

  logic                  commit;
  logic [CW-1:0]         cap_used;
  logic [CNT_W-1:0]      count_next;
  logic                  res_status;
  logic [SLOT_NUM_W-1:0] res_slot;
  logic [ID_W-1:0]       res_id;
  logic [KEY_W-1:0]      res_key;
  logic                  res_full;
  logic                  res_empty;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    scan_t scan_in;
    if (g == 0) begin : g_head
      assign scan_in = '0;
    end else begin : g_link
      assign scan_in = chain[g-1];
    end
    smpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_idx (IDX_W'(g)),
      .wr       (wr),
      .scan_in  (scan_in),
      .scan_out (chain[g])
    );
  end

  assign last     = chain[SLOTS-1];
  assign s_tready = (state == ST_IDLE);
  assign commit   = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    if (CW'(capacity_limit) > CW'(SLOTS)) begin
      cap_used = CW'(SLOTS);
    end else begin
      cap_used = CW'(capacity_limit);
    end
  end

  always_comb begin
    res_status = 1'b0;
    res_slot   = '0;
    res_id     = '0;
    res_key    = '0;
    count_next = count;
    wr         = '0;
    case (cmd)
      CMD_ENQ: begin
        if (CW'(count) < cap_used && last.free_found) begin
          wr.fill    = commit;
          wr.idx     = last.free_idx;
          wr.key     = leave_key;
          wr.id      = item_id;
          count_next = count + CNT_W'(1);
          res_slot   = SLOT_NUM_W'(last.free_idx) + SLOT_NUM_W'(1);
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_SERVE, CMD_PEEK: begin
        if (last.min_found) begin
          res_slot = SLOT_NUM_W'(last.min_idx) + SLOT_NUM_W'(1);
          res_id   = last.min_id;
          res_key  = last.min_key;
          if (cmd == CMD_SERVE) begin
            wr.drain = commit;
            wr.idx   = last.min_idx;
            if (count != '0) begin
              count_next = count - CNT_W'(1);
            end
          end
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_CLEAR: begin
        wr.clear_all = commit;
        count_next   = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    res_full  = (CW'(count_next) >= cap_used);
    res_empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_W'(SLOTS);
    end else if (cfg_wr_en) begin
      capacity_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd       <= cmd_t'(s_tuser);
            item_id   <= s_tdata[ID_W-1:0];
            leave_key <= s_tdata[ID_W +: KEY_W];
            cnt       <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SLOTS)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            count    <= count_next;
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {res_empty, res_full, SLOT_NUM_W'(count_next),
                         res_key, res_id, res_slot};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
